/* rtl/block_buffer_cache_lru_defines.svh */
// assertion macros for the buffer cache block
// used by block_buffer_cache_lru; needs clk_i and rst_ni in scope
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) else $error(msg);

`endif

/* rtl/bbc_pkg.sv */
// shared types and constants of the buffer cache block
// no dependencies
package bbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int SLOT_W      = 5;
  localparam int DEV_W       = 16;
  localparam int BLK_W       = 32;
  localparam int REF_W       = 8;
  localparam int TICK_W      = 32;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOBUF = 2'd1,
    ST_COUNT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WR_HIT   = 2'd0,
    WR_ALLOC = 2'd1,
    WR_INC   = 2'd2,
    WR_DEC   = 2'd3
  } wr_e;

  // request fields held for the whole scan
  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] sidx;
  } req_t;

  // scan record carried from cell to cell
  typedef struct packed {
    logic              v;
    logic              m_found;
    logic [IDX_W-1:0]  m_idx;
    logic [REF_W-1:0]  m_refs;
    logic              m_valid;
    logic              u_stop;
    logic              p_found;
    logic [IDX_W-1:0]  p_idx;
    logic [TICK_W-1:0] p_old;
    logic [REF_W-1:0]  s_refs;
  } scan_t;

  // update broadcast to all cells
  typedef struct packed {
    logic              we;
    wr_e               op;
    logic [IDX_W-1:0]  idx;
    logic              stamp;
    logic [TICK_W-1:0] now;
  } wcmd_t;

endpackage

/* rtl/block_buffer_cache_lru.sv */
// top level of the buffer cache with timestamp lru replacement
// depends on bbc_pkg, bbc_cell and block_buffer_cache_lru_defines.svh
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | req_type, device_id, block_number,
//           |           |                       | slot_index, now_tick
//   out     | output    | out_valid_o/out_stall_i | result_slot, was_hit, needs_fill,
//           |           |                       | status, ref_count_after
//
// each request is captured, then the scan record walks the cell chain through one
// register per slot, and the result and write-back are taken from the finished scan.
// one request is in flight at a time; the next beat can be taken in the cycle
// the previous result is taken, a stalled result holds the input stalled.
// reset clears owned, valid, counts, ticks.
`include "block_buffer_cache_lru_defines.svh"
module block_buffer_cache_lru (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] device_id_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  slot_index_i,
  input  logic [31:0] now_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_slot_o,
  output logic        was_hit_o,
  output logic        needs_fill_o,
  output logic [1:0]  status_o,
  output logic [7:0]  ref_count_after_o
);

  localparam int N = bbc_pkg::NUM_BUFFERS;

  logic                       busy_q, start_q, out_valid_q;
  bbc_pkg::req_t              req_q;
  bbc_pkg::req_e              op_q;
  logic [bbc_pkg::TICK_W-1:0] now_q;
  bbc_pkg::scan_t             chain [N+1];
  bbc_pkg::scan_t             last;
  bbc_pkg::wcmd_t             wcmd;
  logic                       accept, done;
  logic [bbc_pkg::SLOT_W-1:0] r_slot_d, r_slot_q;
  logic                       r_hit_d, r_hit_q, r_fill_d, r_fill_q;
  bbc_pkg::status_e           r_st_d, r_st_q;
  logic [bbc_pkg::REF_W-1:0]  r_refs_d, r_refs_q;

  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign last       = chain[N];
  assign done       = busy_q && last.v;

  // capture request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.dev  <= device_id_i;
      req_q.blk  <= block_number_i;
      req_q.sidx <= slot_index_i;
      op_q       <= bbc_pkg::req_e'(req_type_i);
      now_q      <= now_tick_i;
    end
  end

  // empty scan record injected at the head of the chain
  always_comb begin
    chain[0]       = '0;
    chain[0].v     = start_q;
    chain[0].p_old = '1;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    bbc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (bbc_pkg::IDX_W'(g)),
      .req_i  (req_q),
      .scan_i (chain[g]),
      .wcmd_i (wcmd),
      .scan_o (chain[g+1])
    );
  end

  // decide result and write-back from the finished scan
  always_comb begin
    wcmd       = '0;
    wcmd.now   = now_q;
    r_slot_d   = '0;
    r_hit_d    = 1'b0;
    r_fill_d   = 1'b0;
    r_st_d     = bbc_pkg::ST_OK;
    r_refs_d   = '0;
    if (op_q == bbc_pkg::REQ_GET) begin
      if (last.m_found) begin
        r_slot_d = bbc_pkg::SLOT_W'(last.m_idx);
        r_hit_d  = 1'b1;
        if (last.m_refs == bbc_pkg::REF_MAX) begin
          r_st_d   = bbc_pkg::ST_COUNT;
          r_refs_d = last.m_refs;
        end else begin
          wcmd.we  = done;
          wcmd.op  = bbc_pkg::WR_HIT;
          wcmd.idx = last.m_idx;
          r_fill_d = !last.m_valid;
          r_refs_d = last.m_refs + 1'b1;
        end
      end else if (last.p_found) begin
        wcmd.we  = done;
        wcmd.op  = bbc_pkg::WR_ALLOC;
        wcmd.idx = last.p_idx;
        r_slot_d = bbc_pkg::SLOT_W'(last.p_idx);
        r_fill_d = 1'b1;
        r_refs_d = bbc_pkg::REF_W'(1);
      end else begin
        r_st_d = bbc_pkg::ST_NOBUF;
      end
    end else begin
      r_slot_d = req_q.sidx;
      if (int'(req_q.sidx) >= N) begin
        r_st_d = bbc_pkg::ST_NOBUF;
      end else if (op_q == bbc_pkg::REQ_PIN) begin
        if (last.s_refs == bbc_pkg::REF_MAX) begin
          r_st_d   = bbc_pkg::ST_COUNT;
          r_refs_d = last.s_refs;
        end else begin
          wcmd.we  = done;
          wcmd.op  = bbc_pkg::WR_INC;
          wcmd.idx = bbc_pkg::IDX_W'(req_q.sidx);
          r_refs_d = last.s_refs + 1'b1;
        end
      end else begin
        if (last.s_refs == '0) begin
          r_st_d = bbc_pkg::ST_COUNT;
        end else begin
          wcmd.we    = done;
          wcmd.op    = bbc_pkg::WR_DEC;
          wcmd.idx   = bbc_pkg::IDX_W'(req_q.sidx);
          wcmd.stamp = (op_q == bbc_pkg::REQ_RELEASE) && last.s_refs == bbc_pkg::REF_W'(1);
          r_refs_d   = last.s_refs - 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      r_slot_q <= r_slot_d;
      r_hit_q  <= r_hit_d;
      r_fill_q <= r_fill_d;
      r_st_q   <= r_st_d;
      r_refs_q <= r_refs_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_slot_o     = r_slot_q;
  assign was_hit_o         = r_hit_q;
  assign needs_fill_o      = r_fill_q;
  assign status_o          = r_st_q;
  assign ref_count_after_o = r_refs_q;

  // checks
  `BBC_ASSERT_NXT(a_accept_busy, accept, busy_q && start_q, "accepted beat did not start a scan")
  `BBC_ASSERT_IMP(a_done_room, done, !out_valid_q || !out_stall_i, "scan done with result pending")
  `BBC_ASSERT_IMP(a_write_done, wcmd.we, done, "write-back outside scan end")
  `BBC_ASSERT_NXT(a_done_out, done, out_valid_q && !busy_q, "finished scan gave no result")

endmodule

/* rtl/bbc_cell.sv */
// one buffer slot of the cache and its stage of the scan chain
// depends on bbc_pkg
module bbc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bbc_pkg::IDX_W-1:0] idx_i,
  input  bbc_pkg::req_t             req_i,
  input  bbc_pkg::scan_t            scan_i,
  input  bbc_pkg::wcmd_t            wcmd_i,
  output bbc_pkg::scan_t            scan_o
);

  logic                       owned_q;
  logic                       valid_q;
  logic [bbc_pkg::REF_W-1:0]  refs_q;
  logic [bbc_pkg::TICK_W-1:0] last_q;
  logic [bbc_pkg::DEV_W-1:0]  dev_q;
  logic [bbc_pkg::BLK_W-1:0]  blk_q;
  bbc_pkg::scan_t             scan_d, scan_q;
  logic                       sel;

  // fold this slot into the scan record
  always_comb begin
    scan_d = scan_i;
    if (owned_q && dev_q == req_i.dev && blk_q == req_i.blk && !scan_i.m_found) begin
      scan_d.m_found = 1'b1;
      scan_d.m_idx   = idx_i;
      scan_d.m_refs  = refs_q;
      scan_d.m_valid = valid_q;
    end
    if (!scan_i.u_stop) begin
      if (!owned_q) begin
        scan_d.u_stop  = 1'b1;
        scan_d.p_found = 1'b1;
        scan_d.p_idx   = idx_i;
      end else if (refs_q == '0 && (!scan_i.p_found || last_q < scan_i.p_old)) begin
        scan_d.p_found = 1'b1;
        scan_d.p_idx   = idx_i;
        scan_d.p_old   = last_q;
      end
    end
    if (int'(idx_i) == int'(req_i.sidx)) begin
      scan_d.s_refs = refs_q;
    end
  end

  // scan record register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;
  assign sel    = wcmd_i.we && wcmd_i.idx == idx_i;

  // slot state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned_q <= 1'b0;
      valid_q <= 1'b0;
      refs_q  <= '0;
      last_q  <= '0;
    end else if (sel) begin
      case (wcmd_i.op)
        bbc_pkg::WR_HIT: begin
          refs_q  <= refs_q + 1'b1;
          valid_q <= 1'b1;
        end
        bbc_pkg::WR_ALLOC: begin
          owned_q <= 1'b1;
          valid_q <= 1'b1;
          refs_q  <= bbc_pkg::REF_W'(1);
        end
        bbc_pkg::WR_INC: begin
          refs_q <= refs_q + 1'b1;
        end
        bbc_pkg::WR_DEC: begin
          refs_q <= refs_q - 1'b1;
          if (wcmd_i.stamp) begin
            last_q <= wcmd_i.now;
          end
        end
        default: begin
          refs_q <= refs_q;
        end
      endcase
    end
  end

  // tag written on allocation
  always_ff @(posedge clk_i) begin
    if (sel && wcmd_i.op == bbc_pkg::WR_ALLOC) begin
      dev_q <= req_i.dev;
      blk_q <= req_i.blk;
    end
  end

endmodule
